[src/sctb_pkg.sv]
// Shared types and constants for the strike counting ban table.
// Used by sctb_cell and strike_counting_ban_table_core; no dependencies.
package sctb_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CMD_W       = 3;
    localparam int KEY_W       = 64;
    localparam int TIME_W      = 48;
    localparam int STRIKE_W    = 16;
    localparam int SEC_W       = 32;
    localparam int ENTRY_W     = 7;
    localparam int MS_W        = SEC_W + 10;

    localparam int S_TDATA_W   = 120;
    localparam int M_TDATA_W   = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [MS_W-1:0]     MS_PER_S      = MS_W'(1000);
    localparam logic [STRIKE_W-1:0] STRIKE_MAX    = '1;

    localparam logic [STRIKE_W-1:0] LIMIT_RST     = STRIKE_W'(5);
    localparam logic [SEC_W-1:0]    WINDOW_RST    = SEC_W'(60);
    localparam logic [SEC_W-1:0]    BAN_RST       = SEC_W'(600);

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECK  = 3'd0,
        CMD_STRIKE = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_SWEEP  = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        REG_LIMIT  = 2'd0,
        REG_WINDOW = 2'd1,
        REG_BAN    = 2'd2
    } reg_idx_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_e;

    // Request token that walks the cell chain and collects the outcome.
    typedef struct packed {
        logic                active;
        cmd_e                cmd;
        logic [KEY_BITS-1:0] key;
        logic [TIME_W-1:0]   now;
        logic                hit;
        logic                refused;
        logic                free_found;
        logic [IDX_W-1:0]    free_idx;
        logic [CNT_W-1:0]    drops;
    } tok_t;

    // Aging thresholds; the window and ban times are already scaled to milliseconds.
    typedef struct packed {
        logic [STRIKE_W-1:0] limit;
        logic [MS_W-1:0]     window_ms;
        logic [MS_W-1:0]     ban_ms;
    } cfg_t;

    // Insert data broadcast to all cells; each cell has its own enable.
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TIME_W-1:0]   now;
    } ins_t;

endpackage

[src/strike_counting_ban_table_core.sv]
// Top level of the strike counting ban table: stream ports, APB registers,
// request sequencing and the chain of entry cells. Depends on sctb_pkg, sctb_cell.

// The block keeps up to TABLE_DEPTH address keys, each with a strike count and
// the time of its last strike, in a row of entry cells. A request (check,
// strike, remove, clear or sweep) enters cell 0 and moves one cell per clock
// toward the far end; each cell acts on its own entry as the request passes
// and adds its finding (key hit, refusal, lowest free entry, entries dropped)
// to the request. After the last cell the request is captured in a finishing
// register; once the output register is free, the block writes a new key into
// the lowest free entry when a strike missed and places the result in the
// output register. A new request is accepted once the previous one has placed
// its result, even while that result still waits on m_tready; a result still
// waiting when the next one is ready holds that next request in the finishing
// step until m_tready. Sweep ages an entry by comparing the elapsed milliseconds
// with the window or ban time times one thousand, which is the same as
// comparing whole elapsed seconds. Registers lie at byte addresses 0
// (strike_limit), 4 (strike_window_s) and 8 (ban_time_s) and may only be
// written while the block is idle.
module strike_counting_ban_table_core
    import sctb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Bits from the lowest up: cmd[2:0], key[66:3], now_ms[114:67], zero padding.
    input  logic [S_TDATA_W-1:0] s_tdata,

    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Bits from the lowest up: pass[0], entry_count[7:1], status[8], zero padding.
    output logic [M_TDATA_W-1:0] m_tdata,

    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // Configuration registers. The aging limits are also kept in
    // milliseconds so that the cells never have to divide.
    // ------------------------------------------------------------------
    logic [STRIKE_W-1:0] limit_reg;
    logic [SEC_W-1:0]    window_reg;
    logic [SEC_W-1:0]    ban_reg;
    logic [MS_W-1:0]     window_ms_reg;
    logic [MS_W-1:0]     ban_ms_reg;
    logic                cfg_wr;
    reg_idx_e            cfg_idx;
    cfg_t                cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_e'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= LIMIT_RST;
            window_reg    <= WINDOW_RST;
            ban_reg       <= BAN_RST;
            window_ms_reg <= MS_W'(WINDOW_RST) * MS_PER_S;
            ban_ms_reg    <= MS_W'(BAN_RST) * MS_PER_S;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LIMIT: begin
                    limit_reg <= pwdata[STRIKE_W-1:0];
                end
                REG_WINDOW: begin
                    window_reg    <= pwdata;
                    window_ms_reg <= MS_W'(pwdata) * MS_PER_S;
                end
                REG_BAN: begin
                    ban_reg    <= pwdata;
                    ban_ms_reg <= MS_W'(pwdata) * MS_PER_S;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_LIMIT:  prdata = DATA_W'(limit_reg);
            REG_WINDOW: prdata = window_reg;
            REG_BAN:    prdata = ban_reg;
            default:    prdata = '0;
        endcase
    end

    assign cfg.limit     = limit_reg;
    assign cfg.window_ms = window_ms_reg;
    assign cfg.ban_ms    = ban_ms_reg;

    // ------------------------------------------------------------------
    // Sequencer: idle, request in the chain, finish.
    // ------------------------------------------------------------------
    state_e state_reg, state_next;
    tok_t   tok_chain [TABLE_DEPTH+1];
    tok_t   fin_reg;
    logic   s_accept;
    logic   fin_load;
    logic   finish;
    logic   out_free;

    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [CNT_W-1:0]    total_reg, total_next;

    assign out_free = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_RUN;
            ST_RUN:  if (tok_chain[TABLE_DEPTH].active) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        fin_load = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_RUN:  fin_load = tok_chain[TABLE_DEPTH].active;
            ST_DONE: finish   = out_free;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The request enters the chain straight from the stream.
    always_comb begin
        tok_chain[0]            = '0;
        tok_chain[0].active     = s_accept;
        tok_chain[0].cmd        = cmd_e'(s_tdata[2:0]);
        tok_chain[0].key        = KEY_BITS'(s_tdata[3 +: KEY_W]);
        tok_chain[0].now        = s_tdata[3 + KEY_W +: TIME_W];
    end

    // The last cell shows the finished request for one cycle only.
    always_ff @(posedge aclk) begin
        if (fin_load) begin
            fin_reg <= tok_chain[TABLE_DEPTH];
        end
    end

    // ------------------------------------------------------------------
    // Finishing step: a strike that found no entry claims the lowest free
    // entry, or reports a full table.
    // ------------------------------------------------------------------
    logic strike_miss;
    logic do_insert;
    logic status;
    logic pass;
    ins_t ins;
    logic [TABLE_DEPTH-1:0] ins_en;

    assign strike_miss = (fin_reg.cmd == CMD_STRIKE) && !fin_reg.hit;
    assign do_insert   = strike_miss && fin_reg.free_found;
    assign status      = strike_miss && !fin_reg.free_found;
    assign pass        = (fin_reg.cmd == CMD_CHECK) && !fin_reg.refused;
    assign ins.key     = fin_reg.key;
    assign ins.now     = fin_reg.now;

    always_comb begin
        if (fin_reg.cmd == CMD_CLEAR) begin
            total_next = '0;
        end else begin
            total_next = total_reg - fin_reg.drops + CNT_W'(do_insert);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (finish) begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_data_reg <= M_TDATA_W'({status, ENTRY_W'(total_next), pass});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Chain of entry cells.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        assign ins_en[i] = finish && do_insert && (fin_reg.free_idx == IDX_W'(i));

        sctb_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .cfg      (cfg),
            .ins_en   (ins_en[i]),
            .ins      (ins),
            .tok_in   (tok_chain[i]),
            .tok_out  (tok_chain[i+1])
        );
    end

endmodule

[src/sctb_cell.sv]
// One table entry of the strike counting ban table, plus one token stage.
// Depends on sctb_pkg.
module sctb_cell
    import sctb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  cfg_t             cfg,
    input  logic             ins_en,
    input  ins_t             ins,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [STRIKE_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    tok_t                tok_reg, tok_next;

    logic              match;
    logic [TIME_W-1:0] elapsed;
    logic [MS_W-1:0]   lim_ms;
    logic              aged;

    assign match   = valid_reg && (key_reg == tok_in.key);
    assign elapsed = (tok_in.now >= time_reg) ? (tok_in.now - time_reg) : '0;
    assign lim_ms  = (cnt_reg < cfg.limit) ? cfg.window_ms : cfg.ban_ms;
    // Whole elapsed seconds reach the limit exactly when the elapsed
    // milliseconds reach the limit times one thousand.
    assign aged    = elapsed >= TIME_W'(lim_ms);

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        time_next  = time_reg;
        tok_next   = tok_in;
        if (ins_en) begin
            valid_next = 1'b1;
            key_next   = ins.key;
            cnt_next   = '0;
            time_next  = ins.now;
        end else if (tok_in.active) begin
            case (tok_in.cmd)
                CMD_CHECK: begin
                    if (match) begin
                        tok_next.hit     = 1'b1;
                        tok_next.refused = (cnt_reg >= cfg.limit);
                    end
                end
                CMD_STRIKE: begin
                    if (match) begin
                        tok_next.hit = 1'b1;
                        cnt_next     = (cnt_reg == STRIKE_MAX) ? cnt_reg
                                                               : cnt_reg + 1'b1;
                        time_next    = tok_in.now;
                    end else if (!valid_reg && !tok_in.free_found) begin
                        tok_next.free_found = 1'b1;
                        tok_next.free_idx   = cell_idx;
                    end
                end
                CMD_REMOVE: begin
                    if (match) begin
                        valid_next     = 1'b0;
                        tok_next.drops = tok_in.drops + 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    valid_next = 1'b0;
                end
                CMD_SWEEP: begin
                    if (valid_reg && aged) begin
                        valid_next     = 1'b0;
                        tok_next.drops = tok_in.drops + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            tok_reg.active <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        cnt_reg  <= cnt_next;
        time_reg <= time_next;
    end

    assign tok_out = tok_reg;

endmodule
